// ----- sv/u8u2_pkg.sv -----
// shared constants and types for the utf-8 to ucs-2 decoder
`timescale 1ns / 1ps

package u8u2_pkg;

  // stop status codes carried with each result
  typedef enum logic [1:0] {
    STOP_NONE      = 2'd0,
    STOP_ABOVE_BMP = 2'd1,
    STOP_SURROGATE = 2'd2
  } stop_t;

  // lead byte payload masks
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
  localparam logic [20:0] BMP_MAX          = 21'h00FFFF;
  localparam logic [20:0] SURROGATE_LO     = 21'h00D800;
  localparam logic [20:0] SURROGATE_HI     = 21'h00DFFF;

  // one decoded result as held in the output register
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    stop_t       stop_status;
    logic        out_last;
  } result_t;

endpackage

// ----- sv/utf8_to_ucs2_decoder.sv -----
// utf-8 to ucs-2 decoder: byte stream in, code unit stream out
// an accepted byte passes through the input register and then the output register before its result shows on m_tvalid
// throughput: one byte per cycle while m_tready does not stall the output; bytes inside a sequence give no result
// the decode path is one pass from the input register to the output register
// reset (rst, synchronous, active high) empties both registers and clears
// the pending count, the code point accumulator and the sticky stop status
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst,
  // slave side: raw utf-8 bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // master side: decoded code units
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic [2:0]  m_tuser,   // [0] unit_valid, [2:1] stop_status
  output logic        m_tlast    // out_last
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // decoder state
  logic [1:0]          bytes_pending, bytes_pending_next;
  logic [20:0]         point_accum, point_accum_next;
  u8u2_pkg::stop_t     halt_code, halt_code_next;

  // output register
  logic                out_valid;
  u8u2_pkg::result_t   result, result_next;

  // combinational decode signals
  logic        out_free;
  logic        step;
  logic        emit;
  logic        done;
  logic [1:0]  pend_merge;
  logic [20:0] acc_merge;
  logic [20:0] code_point;

  // the output register can take a new result when empty or being drained
  assign out_free = !out_valid || m_tready;
  // the byte in the input register is decoded when the output can take it
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_comb begin
    pend_merge         = bytes_pending;
    acc_merge          = point_accum;
    code_point         = '0;
    done               = 1'b0;
    emit               = 1'b0;
    result_next        = '0;
    result_next.stop_status = u8u2_pkg::STOP_NONE;
    result_next.out_last    = in_last;
    bytes_pending_next = bytes_pending;
    point_accum_next   = point_accum;
    halt_code_next     = halt_code;

    if (halt_code != u8u2_pkg::STOP_NONE) begin
      // stopped: drop bytes until the final one, which reports the status
      if (in_last) begin
        emit                    = 1'b1;
        result_next.stop_status = halt_code;
        bytes_pending_next      = '0;
        point_accum_next        = '0;
        halt_code_next          = u8u2_pkg::STOP_NONE;
      end
    end else begin
      if (bytes_pending == 2'd0) begin
        // lead byte sets the sequence length
        if (in_byte inside {[8'h00:8'h7F]}) begin
          code_point = {13'd0, in_byte};
          done       = 1'b1;
        end else if (in_byte inside {[8'hC0:8'hDF]}) begin
          acc_merge  = {13'd0, in_byte & u8u2_pkg::LEAD2_MASK};
          pend_merge = 2'd1;
        end else if (in_byte inside {[8'hE0:8'hEF]}) begin
          acc_merge  = {13'd0, in_byte & u8u2_pkg::LEAD3_MASK};
          pend_merge = 2'd2;
        end else if (in_byte inside {[8'hF0:8'hF7]}) begin
          acc_merge  = {13'd0, in_byte & u8u2_pkg::LEAD4_MASK};
          pend_merge = 2'd3;
        end else begin
          // stray continuation or invalid lead
          code_point = {5'd0, u8u2_pkg::REPLACEMENT_CHAR};
          done       = 1'b1;
        end
      end else begin
        // continuation byte: merge its low six bits unchecked
        acc_merge  = {point_accum[14:0], in_byte[5:0] & u8u2_pkg::CONT_MASK[5:0]};
        pend_merge = bytes_pending - 2'd1;
        if (pend_merge == 2'd0) begin
          code_point = acc_merge;
          done       = 1'b1;
        end
      end

      // string ends inside a sequence: missing bytes count as zero
      if (!done && in_last) begin
        case (pend_merge)
          2'd1:    code_point = {acc_merge[14:0], 6'd0};
          2'd2:    code_point = {acc_merge[8:0], 12'd0};
          2'd3:    code_point = {acc_merge[2:0], 18'd0};
          default: code_point = acc_merge;
        endcase
        done = 1'b1;
      end

      if (done) begin
        emit               = 1'b1;
        bytes_pending_next = '0;
        point_accum_next   = '0;
        if (code_point > u8u2_pkg::BMP_MAX) begin
          result_next.stop_status = u8u2_pkg::STOP_ABOVE_BMP;
          halt_code_next          = u8u2_pkg::STOP_ABOVE_BMP;
        end else if (code_point >= u8u2_pkg::SURROGATE_LO &&
                     code_point <= u8u2_pkg::SURROGATE_HI) begin
          result_next.stop_status = u8u2_pkg::STOP_SURROGATE;
          halt_code_next          = u8u2_pkg::STOP_SURROGATE;
        end else begin
          result_next.code_unit  = code_point[15:0];
          result_next.unit_valid = 1'b1;
        end
        // the final byte always leaves a clean state for the next string
        if (in_last) begin
          halt_code_next = u8u2_pkg::STOP_NONE;
        end
      end else begin
        bytes_pending_next = pend_merge;
        point_accum_next   = acc_merge;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      point_accum   <= '0;
      halt_code     <= u8u2_pkg::STOP_NONE;
    end else if (step) begin
      bytes_pending <= bytes_pending_next;
      point_accum   <= point_accum_next;
      halt_code     <= halt_code_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = result.code_unit;
  assign m_tuser  = {result.stop_status, result.unit_valid};
  assign m_tlast  = result.out_last;

endmodule
